// ----- rtl/prqs_pkg.sv -----
package prqs_pkg;

  localparam int THREAD_SLOTS_DEF    = 8;
  localparam int PRIORITY_LEVELS_DEF = 16;

  // Fixed payload widths of the event and result beats
  localparam int OPCODE_W = 3;
  localparam int PRIO_W   = 5;
  localparam int TARGET_W = 3;
  localparam int RUN_W    = 3;
  localparam int RET_W    = 5;

  localparam logic [RET_W-1:0] RET_ERR = '1;

  typedef enum logic [OPCODE_W-1:0] {
    OP_RUN    = 3'd0,
    OP_EXIT   = 3'd1,
    OP_WAIT   = 3'd2,
    OP_SLEEP  = 3'd3,
    OP_WAKEUP = 3'd4,
    OP_GETID  = 3'd5,
    OP_CHPRI  = 3'd6,
    OP_INTR   = 3'd7
  } opcode_e;

  // Sequencer commands to the datapath
  typedef struct packed {
    logic load;
    logic unlink;
    logic exec;
    logic enq_rd;
    logic enq_wr;
    logic enq_sel_b;
    logic pick_rd;
    logic pick_wr;
    logic out_load;
  } cmd_t;

  // Datapath status back to the sequencer
  typedef struct packed {
    logic down;
    logic enq_skip;
    logic out_free;
  } sts_t;

endpackage

// ----- rtl/prqs_in_if.sv -----
interface prqs_in_if;
  import prqs_pkg::*;

  logic                       valid;
  logic                       ready;
  logic [OPCODE_W-1:0]        opcode;
  logic signed [PRIO_W-1:0]   new_priority;
  logic [TARGET_W-1:0]        target_thread;

  modport source (output valid, opcode, new_priority, target_thread, input ready);
  modport sink   (input valid, opcode, new_priority, target_thread, output ready);

endinterface

// ----- rtl/prqs_out_if.sv -----
interface prqs_out_if;
  import prqs_pkg::*;

  logic                      valid;
  logic                      ready;
  logic [RUN_W-1:0]          running_thread;
  logic signed [RET_W-1:0]   return_value;
  logic                      halted;

  modport source (output valid, running_thread, return_value, halted, input ready);
  modport sink   (input valid, running_thread, return_value, halted, output ready);

endinterface

// ----- rtl/priority_ready_queue_scheduler_top.sv -----
// Fixed-priority FIFO ready-queue scheduler. One event beat (run, exit, wait, sleep, wakeup,
// getid, chpri, interrupt) gives one result beat: the thread chosen to run, the call's return
// value and the sticky halted flag. Events are handled one at a time by a sequencer that walks
// unlink, operation, two queue-tail insert slots and a head search. Each insert slot does a
// registered read of the tail RAM whether it inserts or not, each insert adds a write step,
// and the head lookup reads the head RAM through a registered read before the pick is written.
// Once halted, an event skips the walk and goes straight to its reply. A new event is taken
// while the previous result still waits in the output register; a second result then holds
// the sequencer until the first is taken. Empty queues are tracked in flip-flops, so no
// clearing pass follows reset.
module priority_ready_queue_scheduler_top #(
  parameter int THREAD_SLOTS    = prqs_pkg::THREAD_SLOTS_DEF,
  parameter int PRIORITY_LEVELS = prqs_pkg::PRIORITY_LEVELS_DEF
) (
  input  logic      clk_i,
  input  logic      rst_ni,
  prqs_in_if.sink   evt_i,
  prqs_out_if.source res_o
);
  import prqs_pkg::*;

  cmd_t cmd;
  sts_t sts;
  logic in_ready;

  assign evt_i.ready = in_ready;

  prqs_ctrl u_ctrl (
    .clk_i      (clk_i),
    .rst_ni     (rst_ni),
    .in_valid_i (evt_i.valid),
    .in_ready_o (in_ready),
    .sts_i      (sts),
    .cmd_o      (cmd)
  );

  prqs_dp #(
    .THREAD_SLOTS    (THREAD_SLOTS),
    .PRIORITY_LEVELS (PRIORITY_LEVELS)
  ) u_dp (
    .clk_i            (clk_i),
    .rst_ni           (rst_ni),
    .cmd_i            (cmd),
    .sts_o            (sts),
    .opcode_i         (evt_i.opcode),
    .new_priority_i   (evt_i.new_priority),
    .target_thread_i  (evt_i.target_thread),
    .out_ready_i      (res_o.ready),
    .out_valid_o      (res_o.valid),
    .running_thread_o (res_o.running_thread),
    .return_value_o   (res_o.return_value),
    .halted_o         (res_o.halted)
  );

endmodule

// ----- rtl/prqs_ram.sv -----
module prqs_ram #(
  parameter int WIDTH = 4,
  parameter int DEPTH = 16
) (
  input  logic                     clk_i,
  input  logic                     we_i,
  input  logic [$clog2(DEPTH)-1:0] waddr_i,
  input  logic [WIDTH-1:0]         wdata_i,
  input  logic [$clog2(DEPTH)-1:0] raddr_i,
  output logic [WIDTH-1:0]         rdata_o
);

  logic [WIDTH-1:0] mem_q [DEPTH];

  always_ff @(posedge clk_i) begin
    if (we_i) begin
      mem_q[waddr_i] <= wdata_i;
    end
    rdata_o <= mem_q[raddr_i];
  end

endmodule

// ----- rtl/prqs_ctrl.sv -----
module prqs_ctrl (
  input  logic           clk_i,
  input  logic           rst_ni,
  input  logic           in_valid_i,
  output logic           in_ready_o,
  input  prqs_pkg::sts_t sts_i,
  output prqs_pkg::cmd_t cmd_o
);
  import prqs_pkg::*;

  localparam logic [2:0] S_IDLE    = 3'd0;
  localparam logic [2:0] S_UNLINK  = 3'd1;
  localparam logic [2:0] S_EXEC    = 3'd2;
  localparam logic [2:0] S_ENQ_RD  = 3'd3;
  localparam logic [2:0] S_ENQ_WR  = 3'd4;
  localparam logic [2:0] S_PICK_RD = 3'd5;
  localparam logic [2:0] S_PICK_WR = 3'd6;
  localparam logic [2:0] S_DONE    = 3'd7;

  logic [2:0] state_q, state_d;
  logic       sel_b_q, sel_b_d;

  assign in_ready_o = (state_q == S_IDLE);

  always_comb begin
    state_d = state_q;
    sel_b_d = sel_b_q;
    cmd_o   = '0;
    cmd_o.enq_sel_b = sel_b_q;
    unique case (state_q)
      S_IDLE: begin
        if (in_valid_i) begin
          cmd_o.load = 1'b1;
          state_d = sts_i.down ? S_DONE : S_UNLINK;
        end
      end
      S_UNLINK: begin
        cmd_o.unlink = 1'b1;
        state_d = S_EXEC;
      end
      S_EXEC: begin
        cmd_o.exec = 1'b1;
        sel_b_d = 1'b0;
        state_d = S_ENQ_RD;
      end
      S_ENQ_RD: begin
        cmd_o.enq_rd = 1'b1;
        if (!sts_i.enq_skip) begin
          state_d = S_ENQ_WR;
        end else if (!sel_b_q) begin
          sel_b_d = 1'b1;
        end else begin
          state_d = S_PICK_RD;
        end
      end
      S_ENQ_WR: begin
        cmd_o.enq_wr = 1'b1;
        if (!sel_b_q) begin
          sel_b_d = 1'b1;
          state_d = S_ENQ_RD;
        end else begin
          state_d = S_PICK_RD;
        end
      end
      S_PICK_RD: begin
        cmd_o.pick_rd = 1'b1;
        state_d = S_PICK_WR;
      end
      S_PICK_WR: begin
        cmd_o.pick_wr = 1'b1;
        state_d = S_DONE;
      end
      S_DONE: begin
        // hold until the result register is free
        if (sts_i.out_free) begin
          cmd_o.out_load = 1'b1;
          state_d = S_IDLE;
        end
      end
    endcase
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      state_q <= S_IDLE;
      sel_b_q <= 1'b0;
    end else begin
      state_q <= state_d;
      sel_b_q <= sel_b_d;
    end
  end

  a_accept_next: assert property (@(posedge clk_i) disable iff (!rst_ni)
    in_valid_i && in_ready_o |=> (state_q == S_UNLINK) || (state_q == S_DONE))
    else $error("accepted beat did not start unlink or direct reply");

  a_cmd_onehot: assert property (@(posedge clk_i) disable iff (!rst_ni)
    $onehot0({cmd_o.load, cmd_o.unlink, cmd_o.exec, cmd_o.enq_rd, cmd_o.enq_wr,
              cmd_o.pick_rd, cmd_o.pick_wr, cmd_o.out_load}))
    else $error("more than one datapath command in a cycle");

  a_enq_wr_follows_rd: assert property (@(posedge clk_i) disable iff (!rst_ni)
    cmd_o.enq_wr |-> $past(cmd_o.enq_rd) && ($past(sel_b_q) == sel_b_q))
    else $error("enqueue write without matching tail read");

endmodule

// ----- rtl/prqs_dp.sv -----
module prqs_dp #(
  parameter int THREAD_SLOTS    = prqs_pkg::THREAD_SLOTS_DEF,
  parameter int PRIORITY_LEVELS = prqs_pkg::PRIORITY_LEVELS_DEF
) (
  input  logic                                  clk_i,
  input  logic                                  rst_ni,
  input  prqs_pkg::cmd_t                        cmd_i,
  output prqs_pkg::sts_t                        sts_o,
  input  logic [prqs_pkg::OPCODE_W-1:0]         opcode_i,
  input  logic signed [prqs_pkg::PRIO_W-1:0]    new_priority_i,
  input  logic [prqs_pkg::TARGET_W-1:0]         target_thread_i,
  input  logic                                  out_ready_i,
  output logic                                  out_valid_o,
  output logic [prqs_pkg::RUN_W-1:0]            running_thread_o,
  output logic signed [prqs_pkg::RET_W-1:0]     return_value_o,
  output logic                                  halted_o
);
  import prqs_pkg::*;

  localparam int SIW = $clog2(THREAD_SLOTS);
  localparam int SNW = $clog2(THREAD_SLOTS + 1);
  localparam int PW  = $clog2(PRIORITY_LEVELS);
  localparam logic [SNW-1:0] NO_SLOT  = SNW'(THREAD_SLOTS);
  localparam logic [31:0]    SLOTS_U  = 32'(THREAD_SLOTS);
  localparam logic [31:0]    LEVELS_U = 32'(PRIORITY_LEVELS);

  // event registers
  opcode_e                  op_q;
  logic signed [PRIO_W-1:0] prio_q;
  logic [TARGET_W-1:0]      target_q;
  logic [RET_W-1:0]         ret_q;

  // scheduler state
  logic [THREAD_SLOTS-1:0]    used_q, ready_q;
  logic [PRIORITY_LEVELS-1:0] nonempty_q;
  logic [PW-1:0]              slot_prio_q [THREAD_SLOTS];
  logic [SNW-1:0]             slot_next_q [THREAD_SLOTS];
  logic [SNW-1:0]             running_q;
  logic                       down_q;

  // enqueue plan: A is the caller, B the new or woken thread
  logic            plan_a_q, plan_b_q;
  logic [SIW-1:0]  plan_b_slot_q;

  logic                 out_valid_q, out_halt_q;
  logic [RUN_W-1:0]     out_run_q;
  logic [RET_W-1:0]     out_ret_q;

  logic            cur_valid;
  logic [SIW-1:0]  cur_idx;
  logic [SIW-1:0]  enq_slot;
  logic            enq_valid;
  logic [SIW-1:0]  slot_addr;
  logic [PW-1:0]   sp;
  logic [SNW-1:0]  sn;
  logic            prio_ok, target_ok;
  logic [SIW-1:0]  target_idx;
  logic [PW-1:0]   new_prio;
  logic            free_found;
  logic [SIW-1:0]  free_idx;
  logic            pick_any;
  logic [PW-1:0]   pick_idx;
  logic            unlink_en;
  logic            head_we;
  logic [SIW-1:0]  head_wdata, head_rdata, tail_rdata;

  assign cur_valid  = (running_q < NO_SLOT);
  assign cur_idx    = SIW'(running_q);
  assign enq_slot   = cmd_i.enq_sel_b ? plan_b_slot_q : cur_idx;
  assign enq_valid  = cmd_i.enq_sel_b ? plan_b_q : plan_a_q;
  assign slot_addr  = (cmd_i.enq_rd || cmd_i.enq_wr) ? enq_slot : cur_idx;
  assign sp         = slot_prio_q[slot_addr];
  assign sn         = slot_next_q[slot_addr];

  assign prio_ok    = !prio_q[PRIO_W-1] && ({{(32-PRIO_W+1){1'b0}}, prio_q[PRIO_W-2:0]} < LEVELS_U);
  assign new_prio   = PW'(prio_q[PRIO_W-2:0]);
  assign target_ok  = ({{(32-TARGET_W){1'b0}}, target_q} < SLOTS_U);
  assign target_idx = SIW'(target_q);

  assign unlink_en  = cmd_i.unlink && (op_q != OP_INTR) && cur_valid && ready_q[cur_idx];

  // lowest free slot
  always_comb begin
    free_found = 1'b0;
    free_idx   = '0;
    for (int i = THREAD_SLOTS - 1; i >= 0; i--) begin
      if (!used_q[i]) begin
        free_found = 1'b1;
        free_idx   = SIW'(i);
      end
    end
  end

  // lowest non-empty priority queue
  always_comb begin
    pick_any = 1'b0;
    pick_idx = '0;
    for (int i = PRIORITY_LEVELS - 1; i >= 0; i--) begin
      if (nonempty_q[i]) begin
        pick_any = 1'b1;
        pick_idx = PW'(i);
      end
    end
  end

  assign head_we    = unlink_en || (cmd_i.enq_wr && !nonempty_q[sp]);
  assign head_wdata = cmd_i.enq_wr ? enq_slot : SIW'(sn);

  prqs_ram #(.WIDTH(SIW), .DEPTH(PRIORITY_LEVELS)) u_head_ram (
    .clk_i   (clk_i),
    .we_i    (head_we),
    .waddr_i (sp),
    .wdata_i (head_wdata),
    .raddr_i (pick_idx),
    .rdata_o (head_rdata)
  );

  prqs_ram #(.WIDTH(SIW), .DEPTH(PRIORITY_LEVELS)) u_tail_ram (
    .clk_i   (clk_i),
    .we_i    (cmd_i.enq_wr),
    .waddr_i (sp),
    .wdata_i (enq_slot),
    .raddr_i (sp),
    .rdata_o (tail_rdata)
  );

  assign sts_o.down     = down_q;
  assign sts_o.enq_skip = !enq_valid || ready_q[enq_slot];
  assign sts_o.out_free = !out_valid_q || out_ready_i;

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      used_q      <= '0;
      ready_q     <= '0;
      nonempty_q  <= '0;
      running_q   <= NO_SLOT;
      down_q      <= 1'b0;
      plan_a_q    <= 1'b0;
      plan_b_q    <= 1'b0;
      out_valid_q <= 1'b0;
    end else begin
      if (unlink_en) begin
        ready_q[cur_idx] <= 1'b0;
        if (sn >= NO_SLOT) begin
          nonempty_q[sp] <= 1'b0;
        end
      end
      if (cmd_i.exec) begin
        plan_a_q <= 1'b0;
        plan_b_q <= 1'b0;
        unique case (op_q) inside
          OP_RUN: begin
            if (free_found && prio_ok) begin
              used_q[free_idx]  <= 1'b1;
              ready_q[free_idx] <= 1'b0;
              plan_a_q <= cur_valid;
              plan_b_q <= 1'b1;
            end
          end
          OP_EXIT: begin
            if (cur_valid) begin
              used_q[cur_idx]  <= 1'b0;
              ready_q[cur_idx] <= 1'b0;
            end
          end
          OP_WAIT, OP_GETID, OP_CHPRI: plan_a_q <= cur_valid;
          OP_WAKEUP: begin
            plan_a_q <= cur_valid;
            plan_b_q <= target_ok && used_q[target_idx];
          end
          OP_SLEEP, OP_INTR: ;
        endcase
      end
      if (cmd_i.enq_wr) begin
        nonempty_q[sp]    <= 1'b1;
        ready_q[enq_slot] <= 1'b1;
      end
      if (cmd_i.pick_wr) begin
        if (pick_any) begin
          running_q <= SNW'(head_rdata);
        end else begin
          running_q <= NO_SLOT;
          down_q    <= 1'b1;
        end
      end
      if (cmd_i.out_load) begin
        out_valid_q <= 1'b1;
      end else if (out_ready_i) begin
        out_valid_q <= 1'b0;
      end
    end
  end

  always_ff @(posedge clk_i) begin
    if (cmd_i.load) begin
      op_q     <= opcode_e'(opcode_i);
      prio_q   <= new_priority_i;
      target_q <= target_thread_i;
      ret_q    <= '0;
    end
    if (unlink_en) begin
      slot_next_q[cur_idx] <= NO_SLOT;
    end
    if (cmd_i.exec) begin
      plan_b_slot_q <= (op_q == OP_RUN) ? free_idx : target_idx;
      unique case (op_q) inside
        OP_RUN: begin
          if (free_found && prio_ok) begin
            slot_prio_q[free_idx] <= new_prio;
            slot_next_q[free_idx] <= NO_SLOT;
            ret_q <= RET_W'(free_idx);
          end else begin
            ret_q <= RET_ERR;
          end
        end
        OP_GETID: ret_q <= cur_valid ? RET_W'(cur_idx) : RET_ERR;
        OP_CHPRI: begin
          if (cur_valid) begin
            ret_q <= RET_W'(sp);
            if (prio_ok) begin
              slot_prio_q[cur_idx] <= new_prio;
            end
          end else begin
            ret_q <= RET_ERR;
          end
        end
        OP_EXIT, OP_WAIT, OP_SLEEP, OP_WAKEUP, OP_INTR: ;
      endcase
    end
    if (cmd_i.enq_wr) begin
      // link behind the old tail, then terminate the new tail
      if (nonempty_q[sp]) begin
        slot_next_q[tail_rdata] <= SNW'(enq_slot);
      end
      slot_next_q[enq_slot] <= NO_SLOT;
    end
    if (cmd_i.out_load) begin
      out_run_q  <= down_q ? '0 : RUN_W'(running_q);
      out_ret_q  <= ret_q;
      out_halt_q <= down_q;
    end
  end

  assign out_valid_o      = out_valid_q;
  assign running_thread_o = out_run_q;
  assign return_value_o   = out_ret_q;
  assign halted_o         = out_halt_q;

  a_down_sticky: assert property (@(posedge clk_i) disable iff (!rst_ni)
    down_q |=> down_q)
    else $error("halted state was left");

  a_ready_used: assert property (@(posedge clk_i) disable iff (!rst_ni)
    (ready_q & ~used_q) == '0)
    else $error("ready thread in an unused slot");

  a_running_ready: assert property (@(posedge clk_i) disable iff (!rst_ni)
    cmd_i.out_load && !down_q |-> cur_valid && ready_q[cur_idx])
    else $error("chosen thread is not ready");

endmodule

// ----- verif/tb_priority_ready_queue_scheduler_top.sv -----
module tb_priority_ready_queue_scheduler_top;
  timeunit 1ns;
  timeprecision 1ps;

  import prqs_pkg::*;

  localparam int NSLOT  = THREAD_SLOTS_DEF;
  localparam int NLEVEL = PRIORITY_LEVELS_DEF;
  localparam logic [3:0] NONE = 4'(NSLOT);

  typedef struct packed {
    logic [NSLOT-1:0]       used;
    logic [NSLOT-1:0]       ready;
    logic [NSLOT-1:0][3:0]  prio;
    logic [NSLOT-1:0][3:0]  link;
    logic [NLEVEL-1:0][3:0] head;
    logic [NLEVEL-1:0][3:0] tail;
    logic [3:0]             current;
    logic                   down;
  } sched_state_t;

  typedef struct packed {
    logic [RUN_W-1:0]        running_thread;
    logic signed [RET_W-1:0] return_value;
    logic                    halted;
  } decision_t;

  logic clk_i;
  logic rst_ni;

  prqs_in_if  evt_if ();
  prqs_out_if res_if ();

  priority_ready_queue_scheduler_top dut (
    .clk_i  (clk_i),
    .rst_ni (rst_ni),
    .evt_i  (evt_if),
    .res_o  (res_if)
  );

  sched_state_t model;
  decision_t    expected_decisions[$];
  int           mismatch_count = 0;
  bit           burst_mode = 1'b0;

  always begin
    clk_i = 1'b0;
    #1;
    clk_i = 1'b1;
    #1;
  end

  initial begin
    #1_000_000;
    $display("DONE: errors detected");
    $finish;
  end

  function automatic int idle_cycles();
    int r;
    r = $urandom_range(0, 99);
    if (burst_mode || r < 60) return 0;
    if (r < 92) return $urandom_range(1, 3);
    return $urandom_range(8, 30);
  endfunction

  // Append a slot to the tail of its priority queue unless it is already ready.
  function automatic void make_ready(inout sched_state_t s, input logic [3:0] slot);
    logic [3:0] lvl;
    logic [3:0] last;
    if (slot >= NONE) return;
    if (s.ready[slot[2:0]]) return;
    lvl  = s.prio[slot[2:0]];
    last = s.tail[lvl];
    if (last < NONE) s.link[last[2:0]] = slot;
    else s.head[lvl] = slot;
    s.tail[lvl]          = slot;
    s.link[slot[2:0]]    = NONE;
    s.ready[slot[2:0]]   = 1'b1;
  endfunction

  function automatic decision_t schedule_event(inout sched_state_t s, input opcode_e op,
                                               input logic signed [PRIO_W-1:0] prio,
                                               input logic [TARGET_W-1:0] tgt);
    decision_t               d;
    logic [3:0]              caller;
    logic [3:0]              lvl;
    logic [3:0]              free_slot;
    logic signed [RET_W-1:0] ret;
    logic                    prio_ok;
    d = '0;
    d.halted = 1'b1;
    if (s.down) return d;
    ret     = '0;
    prio_ok = (prio >= 0) && (int'(prio) < NLEVEL);

    // System calls pull the caller off the head of its queue first.
    if (op != OP_INTR && s.current < NONE && s.ready[s.current[2:0]]) begin
      lvl = s.prio[s.current[2:0]];
      s.head[lvl] = s.link[s.current[2:0]];
      if (s.head[lvl] >= NONE) begin
        s.head[lvl] = NONE;
        s.tail[lvl] = NONE;
      end
      s.ready[s.current[2:0]] = 1'b0;
      s.link[s.current[2:0]]  = NONE;
    end
    caller = s.current;

    case (op)
      OP_RUN: begin
        free_slot = NONE;
        for (int k = NSLOT - 1; k >= 0; k--) if (!s.used[k]) free_slot = 4'(k);
        if (free_slot == NONE || !prio_ok) begin
          ret = RET_ERR;
        end else begin
          s.used[free_slot[2:0]]  = 1'b1;
          s.ready[free_slot[2:0]] = 1'b0;
          s.prio[free_slot[2:0]]  = prio[3:0];
          s.link[free_slot[2:0]]  = NONE;
          make_ready(s, caller);
          make_ready(s, free_slot);
          ret = RET_W'(free_slot);
        end
      end
      OP_EXIT: begin
        if (caller < NONE) begin
          s.used[caller[2:0]]  = 1'b0;
          s.ready[caller[2:0]] = 1'b0;
          s.prio[caller[2:0]]  = '0;
          s.link[caller[2:0]]  = NONE;
        end
      end
      OP_WAIT: make_ready(s, caller);
      OP_SLEEP: ;
      OP_WAKEUP: begin
        make_ready(s, caller);
        if (s.used[tgt]) make_ready(s, {1'b0, tgt});
      end
      OP_GETID: begin
        if (caller < NONE) begin
          make_ready(s, caller);
          ret = RET_W'(caller);
        end else begin
          ret = RET_ERR;
        end
      end
      OP_CHPRI: begin
        if (caller < NONE) begin
          ret = RET_W'(s.prio[caller[2:0]]);
          if (prio_ok) s.prio[caller[2:0]] = prio[3:0];
          make_ready(s, caller);
        end else begin
          ret = RET_ERR;
        end
      end
      default: ;
    endcase

    // Lowest-numbered non-empty queue wins.
    s.current = NONE;
    for (int k = NLEVEL - 1; k >= 0; k--) if (s.head[k] < NONE) s.current = s.head[k];
    if (s.current == NONE) s.down = 1'b1;

    d.running_thread = s.down ? '0 : s.current[2:0];
    d.return_value   = ret;
    d.halted         = s.down;
    return d;
  endfunction

  // Call at a rising edge; returns at the edge where the beat is accepted.
  task automatic send_event(input opcode_e op, input logic signed [PRIO_W-1:0] prio,
                            input logic [TARGET_W-1:0] tgt);
    int gap;
    gap = idle_cycles();
    if (gap > 0) begin
      evt_if.valid <= 1'b0;
      repeat (gap) @(posedge clk_i);
    end
    evt_if.valid         <= 1'b1;
    evt_if.opcode        <= op;
    evt_if.new_priority  <= prio;
    evt_if.target_thread <= tgt;
    do @(posedge clk_i); while (!evt_if.ready);
    expected_decisions.push_back(schedule_event(model, op, prio, tgt));
  endtask

  task automatic report_mismatch(input string field, input int want, input int got);
    mismatch_count++;
    $display("%0t: %s expected %0d actual %0d", $time, field, want, got);
  endtask

  initial begin : result_monitor
    int        stall;
    decision_t want;
    stall = 0;
    res_if.ready <= 1'b0;
    forever begin
      @(posedge clk_i);
      if (rst_ni && res_if.valid && res_if.ready) begin
        if (expected_decisions.size() == 0) begin
          mismatch_count++;
          $display("%0t: unexpected result beat, running_thread %0d return_value %0d halted %0d",
                   $time, res_if.running_thread, res_if.return_value, res_if.halted);
        end else begin
          want = expected_decisions.pop_front();
          if (res_if.running_thread !== want.running_thread)
            report_mismatch("running_thread", want.running_thread, res_if.running_thread);
          if (res_if.return_value !== want.return_value)
            report_mismatch("return_value", want.return_value, res_if.return_value);
          if (res_if.halted !== want.halted)
            report_mismatch("halted", want.halted, res_if.halted);
        end
      end
      if (stall > 0) begin
        stall--;
        res_if.ready <= 1'b0;
      end else begin
        res_if.ready <= 1'b1;
        stall = idle_cycles();
      end
    end
  end

  // First thread from an empty system, then the priority extremes.
  task automatic test_spawn_priorities();
    send_event(OP_RUN, 5'sd5, 3'd0);
    send_event(OP_RUN, 5'sd15, 3'd7);
    send_event(OP_RUN, 5'sd0, 3'd0);
  endtask

  task automatic test_id_and_priority_change();
    send_event(OP_GETID, 5'sd0, 3'd0);
    send_event(OP_CHPRI, -5'sd1, 3'd0);
    send_event(OP_CHPRI, 5'sd15, 3'd0);
    send_event(OP_INTR, -5'sd16, 3'd7);
  endtask

  task automatic test_wakeup_rules();
    send_event(OP_WAKEUP, 5'sd0, 3'd1);   // already ready
    send_event(OP_WAKEUP, 5'sd0, 3'd7);   // never used
    send_event(OP_SLEEP, 5'sd0, 3'd0);
    send_event(OP_WAKEUP, 5'sd0, 3'd0);
    send_event(OP_WAIT, 5'sd0, 3'd0);
    send_event(OP_WAKEUP, 5'sd0, 3'd0);
  endtask

  task automatic test_exit_and_run_errors();
    send_event(OP_EXIT, 5'sd0, 3'd0);
    send_event(OP_RUN, -5'sd1, 3'd0);
    send_event(OP_WAKEUP, 5'sd0, 3'd2);
    send_event(OP_RUN, -5'sd16, 3'd0);
    send_event(OP_WAKEUP, 5'sd0, 3'd1);
  endtask

  task automatic test_slot_exhaustion();
    repeat (6) send_event(OP_RUN, 5'sd3, 3'd0);
    send_event(OP_RUN, 5'sd7, 3'd0);      // table full
  endtask

  task automatic test_random_traffic(input int count);
    sched_state_t                trial;
    opcode_e                     op;
    logic signed [PRIO_W-1:0]    prio;
    logic [TARGET_W-1:0]         tgt;
    decision_t                   unused_result;
    int                          tries;
    int                          r;
    for (int n = 0; n < count; n++) begin
      if (n % 100 == 0) burst_mode = ($urandom_range(0, 3) == 0);
      tries = 0;
      // Redraw events that would bring the system down too early.
      do begin
        r = $urandom_range(0, 99);
        if (r < 18) op = OP_RUN;
        else if (r < 28) op = OP_EXIT;
        else if (r < 36) op = OP_WAIT;
        else if (r < 48) op = OP_SLEEP;
        else if (r < 70) op = OP_WAKEUP;
        else if (r < 78) op = OP_GETID;
        else if (r < 90) op = OP_CHPRI;
        else op = OP_INTR;
        prio = ($urandom_range(0, 4) == 0) ? PRIO_W'($urandom) : PRIO_W'($urandom_range(0, 15));
        tgt  = TARGET_W'($urandom_range(0, 7));
        trial = model;
        unused_result = schedule_event(trial, op, prio, tgt);
        tries++;
      end while (trial.down && tries < 8);
      if (trial.down) op = OP_INTR;
      send_event(op, prio, tgt);
    end
    burst_mode = 1'b0;
  endtask

  // Drain the ready threads until the system goes down, then poke it.
  task automatic test_halt_sticky();
    while (!model.down) send_event(OP_EXIT, 5'sd0, 3'd0);
    repeat (6)
      send_event(opcode_e'($urandom_range(0, 7)), PRIO_W'($urandom), TARGET_W'($urandom));
  endtask

  initial begin
    model.used    = '0;
    model.ready   = '0;
    model.prio    = '0;
    model.link    = {NSLOT{NONE}};
    model.head    = {NLEVEL{NONE}};
    model.tail    = {NLEVEL{NONE}};
    model.current = NONE;
    model.down    = 1'b0;

    rst_ni               <= 1'b0;
    evt_if.valid         <= 1'b0;
    evt_if.opcode        <= OP_INTR;
    evt_if.new_priority  <= '0;
    evt_if.target_thread <= '0;
    repeat (12) @(posedge clk_i);
    rst_ni <= 1'b1;
    @(posedge clk_i);

    test_spawn_priorities();
    test_id_and_priority_change();
    test_wakeup_rules();
    test_exit_and_run_errors();
    test_slot_exhaustion();
    test_random_traffic(1000);
    test_halt_sticky();

    evt_if.valid <= 1'b0;
    while (expected_decisions.size() != 0) @(posedge clk_i);
    repeat (40) @(posedge clk_i);

    if (mismatch_count == 0 && expected_decisions.size() == 0) begin
      $display("DONE: 0 errors");
    end else begin
      $display("DONE: errors detected");
    end
    $finish;
  end

endmodule
